@@ rtl/cse_pkg.sv @@
// Package for the clock set field editor: request codes, cursor codes,
// field limits, payload structs and the month length function.
// No dependencies.
package cse_pkg;

  typedef enum logic [2:0] {
    REQ_LOAD = 3'd0,
    REQ_MODE = 3'd1,
    REQ_NEXT = 3'd2,
    REQ_INC  = 3'd3,
    REQ_DEC  = 3'd4
  } req_code_t;

  typedef enum logic [2:0] {
    CUR_YEAR    = 3'd1,
    CUR_MONTH   = 3'd2,
    CUR_DAY     = 3'd3,
    CUR_WEEKDAY = 3'd4,
    CUR_HOUR    = 3'd5,
    CUR_MINUTE  = 3'd6,
    CUR_SECOND  = 3'd7
  } cursor_code_t;

  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [3:0] MONTH_MIN  = 4'd1;
  localparam logic [4:0] DAY_MIN    = 5'd1;
  localparam logic [4:0] DAY_LONG   = 5'd31;
  localparam logic [4:0] DAY_SHORT  = 5'd30;
  localparam logic [4:0] DAY_FEB_LP = 5'd29;
  localparam logic [4:0] DAY_FEB    = 5'd28;
  localparam logic [2:0] WDAY_MAX   = 3'd7;
  localparam logic [2:0] WDAY_MIN   = 3'd1;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  // reset values of the editor state
  localparam logic [2:0] RST_CURSOR  = 3'd1;
  localparam logic [6:0] RST_YEAR    = 7'd23;
  localparam logic [3:0] RST_MONTH   = 4'd1;
  localparam logic [4:0] RST_DAY     = 5'd22;
  localparam logic [2:0] RST_WEEKDAY = 3'd0;
  localparam logic [4:0] RST_HOUR    = 5'd23;
  localparam logic [5:0] RST_MINUTE  = 6'd59;
  localparam logic [5:0] RST_SECOND  = 6'd55;
  localparam logic [2:0] RST_OFFSET  = 3'd7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [2:0] load_weekday;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_item_t;

  typedef struct packed {
    logic       editing;
    logic [2:0] cursor_pos;
    logic [6:0] year_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
    logic [2:0] weekday_out;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
    logic [2:0] week_offset_out;
    logic       commit;
  } out_item_t;

  // days in the month, zero when the month code is out of range
  function automatic logic [4:0] month_limit(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] lim;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = DAY_LONG;
      4'd4, 4'd6, 4'd9, 4'd11:                   lim = DAY_SHORT;
      4'd2:    lim = (year[1:0] == 2'b00) ? DAY_FEB_LP : DAY_FEB;
      default: lim = 5'd0;
    endcase
    return lim;
  endfunction

endpackage

@@ rtl/cse_if.sv @@
// Valid/ready channel interfaces for the clock set field editor.
// Depends on nothing; field widths follow cse_pkg payload structs.
interface cse_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [6:0] load_year;
  logic [3:0] load_month;
  logic [4:0] load_day;
  logic [2:0] load_weekday;
  logic [4:0] load_hour;
  logic [5:0] load_minute;
  logic [5:0] load_second;

  modport source (output valid, req_type, load_year, load_month, load_day, load_weekday,
                  load_hour, load_minute, load_second, input ready);
  modport sink (input valid, req_type, load_year, load_month, load_day, load_weekday,
                load_hour, load_minute, load_second, output ready);
endinterface

interface cse_rsp_if;
  logic       valid;
  logic       ready;
  logic       editing;
  logic [2:0] cursor_pos;
  logic [6:0] year_out;
  logic [3:0] month_out;
  logic [4:0] day_out;
  logic [2:0] weekday_out;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [5:0] second_out;
  logic [2:0] week_offset_out;
  logic       commit;

  modport source (output valid, editing, cursor_pos, year_out, month_out, day_out,
                  weekday_out, hour_out, minute_out, second_out, week_offset_out, commit,
                  input ready);
  modport sink (input valid, editing, cursor_pos, year_out, month_out, day_out,
                weekday_out, hour_out, minute_out, second_out, week_offset_out, commit,
                output ready);
endinterface

@@ rtl/clock_set_field_editor_unit.sv @@
// Top level of the clock set field editor: input register, editor core, result register.
// Depends on cse_pkg, cse_if, cse_in_reg, cse_core.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle while the receiver is ready; the input register can
// take a new request while an earlier result waits. Synchronous active-high reset clears
// both stages' valid flags and loads the editor state with its power-on date and time.
module clock_set_field_editor_unit (
  input logic      clk,
  input logic      rst,
  cse_req_if.sink  req,
  cse_rsp_if.source rsp
);
  import cse_pkg::*;

  in_item_t  in_item;
  in_item_t  held_item;
  out_item_t result;
  out_item_t out_q;
  logic      held_valid;
  logic      take;
  logic      out_valid;

  assign in_item.req_type     = req.req_type;
  assign in_item.load_year    = req.load_year;
  assign in_item.load_month   = req.load_month;
  assign in_item.load_day     = req.load_day;
  assign in_item.load_weekday = req.load_weekday;
  assign in_item.load_hour    = req.load_hour;
  assign in_item.load_minute  = req.load_minute;
  assign in_item.load_second  = req.load_second;

  // held item moves on when the result register is free or draining
  assign take = held_valid && (!out_valid || rsp.ready);

  cse_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_item    (in_item),
    .in_ready   (req.ready),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  cse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (take),
    .item    (held_item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_q <= result;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.editing         = out_q.editing;
  assign rsp.cursor_pos      = out_q.cursor_pos;
  assign rsp.year_out        = out_q.year_out;
  assign rsp.month_out       = out_q.month_out;
  assign rsp.day_out         = out_q.day_out;
  assign rsp.weekday_out     = out_q.weekday_out;
  assign rsp.hour_out        = out_q.hour_out;
  assign rsp.minute_out      = out_q.minute_out;
  assign rsp.second_out      = out_q.second_out;
  assign rsp.week_offset_out = out_q.week_offset_out;
  assign rsp.commit          = out_q.commit;

endmodule

@@ rtl/cse_in_reg.sv @@
// Input register stage of the clock set field editor.
// Depends on cse_pkg.
module cse_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  cse_pkg::in_item_t in_item,
  output logic             in_ready,
  input  logic             take,
  output logic             held_valid,
  output cse_pkg::in_item_t held_item
);
  import cse_pkg::*;

  // refill in the same cycle the held item moves on
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

@@ rtl/cse_core.sv @@
// Editor state registers and next-state logic for one request.
// Depends on cse_pkg.
module cse_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  cse_pkg::in_item_t item,
  output cse_pkg::out_item_t result
);
  import cse_pkg::*;

  logic       edit_flag, edit_flag_next;
  logic [2:0] cursor, cursor_next;
  logic [6:0] year, year_next;
  logic [3:0] month, month_next;
  logic [4:0] day, day_next;
  logic [2:0] weekday, weekday_next;
  logic [4:0] hour, hour_next;
  logic [5:0] minute, minute_next;
  logic [5:0] second, second_next;
  logic [2:0] offset, offset_next;
  logic       commit;
  logic [4:0] day_lim;
  logic       up;

  assign day_lim = month_limit(month, year);

  always_comb begin
    edit_flag_next = edit_flag;
    cursor_next    = cursor;
    year_next      = year;
    month_next     = month;
    day_next       = day;
    weekday_next   = weekday;
    hour_next      = hour;
    minute_next    = minute;
    second_next    = second;
    offset_next    = offset;
    commit         = 1'b0;
    up             = (item.req_type == REQ_INC);

    if (!edit_flag) begin
      if (item.req_type == REQ_LOAD) begin
        year_next    = item.load_year;
        month_next   = item.load_month;
        day_next     = item.load_day;
        weekday_next = item.load_weekday;
        hour_next    = item.load_hour;
        minute_next  = item.load_minute;
        second_next  = item.load_second;
      end else if (item.req_type == REQ_MODE) begin
        edit_flag_next = 1'b1;
        cursor_next    = CUR_YEAR;
      end
    end else begin
      if (item.req_type == REQ_MODE) begin
        edit_flag_next = 1'b0;
        commit         = 1'b1;
      end else if (item.req_type == REQ_NEXT) begin
        cursor_next = (cursor >= CUR_SECOND) ? CUR_YEAR : cursor + 3'd1;
      end else if (item.req_type == REQ_INC || item.req_type == REQ_DEC) begin
        case (cursor)
          CUR_YEAR: begin
            if (up) year_next = (year >= YEAR_MAX) ? 7'd0 : year + 7'd1;
            else    year_next = (year == 7'd0) ? YEAR_MAX : year - 7'd1;
          end
          CUR_MONTH: begin
            if (up) month_next = (month >= MONTH_MAX) ? MONTH_MIN : month + 4'd1;
            else    month_next = (month == MONTH_MIN) ? MONTH_MAX : month - 4'd1;
          end
          CUR_DAY: begin
            // out-of-range month leaves the day alone
            if (day_lim != 5'd0) begin
              if (up) day_next = (day >= day_lim) ? DAY_MIN : day + 5'd1;
              else    day_next = (day == DAY_MIN) ? day_lim : day - 5'd1;
            end
          end
          CUR_WEEKDAY: begin
            if (up) begin
              offset_next  = (offset >= WDAY_MAX) ? WDAY_MIN : offset + 3'd1;
              weekday_next = (weekday >= WDAY_MAX) ? WDAY_MIN : weekday + 3'd1;
            end else begin
              offset_next  = (offset == WDAY_MIN) ? WDAY_MAX : offset - 3'd1;
              weekday_next = (weekday == WDAY_MIN) ? WDAY_MAX : weekday - 3'd1;
            end
          end
          CUR_HOUR: begin
            if (up) hour_next = (hour >= HOUR_MAX) ? 5'd0 : hour + 5'd1;
            else    hour_next = (hour == 5'd0) ? HOUR_MAX : hour - 5'd1;
          end
          CUR_MINUTE: begin
            if (up) minute_next = (minute >= MINSEC_MAX) ? 6'd0 : minute + 6'd1;
            else    minute_next = (minute == 6'd0) ? MINSEC_MAX : minute - 6'd1;
          end
          CUR_SECOND: begin
            if (up) second_next = (second >= MINSEC_MAX) ? 6'd0 : second + 6'd1;
            else    second_next = (second == 6'd0) ? MINSEC_MAX : second - 6'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_flag <= 1'b0;
      cursor    <= RST_CURSOR;
      year      <= RST_YEAR;
      month     <= RST_MONTH;
      day       <= RST_DAY;
      weekday   <= RST_WEEKDAY;
      hour      <= RST_HOUR;
      minute    <= RST_MINUTE;
      second    <= RST_SECOND;
      offset    <= RST_OFFSET;
    end else if (step_en) begin
      edit_flag <= edit_flag_next;
      cursor    <= cursor_next;
      year      <= year_next;
      month     <= month_next;
      day       <= day_next;
      weekday   <= weekday_next;
      hour      <= hour_next;
      minute    <= minute_next;
      second    <= second_next;
      offset    <= offset_next;
    end
  end

  always_comb begin
    result.editing         = edit_flag_next;
    result.cursor_pos      = cursor_next;
    result.year_out        = year_next;
    result.month_out       = month_next;
    result.day_out         = day_next;
    result.weekday_out     = weekday_next;
    result.hour_out        = hour_next;
    result.minute_out      = minute_next;
    result.second_out      = second_next;
    result.week_offset_out = offset_next;
    result.commit          = commit;
  end

endmodule

@@ rtl/cse_checker.sv @@
// Port-level checks for the clock set field editor, bound to the top level.
// Depends on clock_set_field_editor_unit and cse_if.
module cse_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       editing,
  input logic       commit,
  input logic [2:0] cursor_pos,
  input logic [2:0] week_offset_out,
  input logic [6:0] year_out
);

  // commit only on the transaction that leaves edit mode
  a_commit_exit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && commit |-> !editing)
    else $error("commit with editing still set");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> cursor_pos != 3'd0)
    else $error("cursor out of range");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> week_offset_out != 3'd0)
    else $error("weekday offset out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(editing) && $stable(commit)
      && $stable(cursor_pos) && $stable(year_out))
    else $error("result changed while stalled");

endmodule

bind clock_set_field_editor_unit cse_checker u_cse_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .editing         (rsp.editing),
  .commit          (rsp.commit),
  .cursor_pos      (rsp.cursor_pos),
  .week_offset_out (rsp.week_offset_out),
  .year_out        (rsp.year_out)
);

@@ tb/sv/tb_clock_set_field_editor_unit.sv @@
// Self-checking testbench for clock_set_field_editor_unit: directed key sequences,
// then random edit sessions, checked against a shadow model of the editor.
// Depends on cse_pkg, cse_if and the RTL of the unit.
`timescale 1ns / 1ps

module tb_clock_set_field_editor_unit;
  import cse_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 40;
  localparam int DRAIN_CYCLES = 8;

  // request codes the unit must ignore
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  typedef struct {
    logic       edit;
    logic [2:0] cursor;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] offset;
  } editor_state_t;

  typedef struct {
    in_item_t  key;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cse_req_if req_ch ();
  cse_rsp_if rsp_ch ();

  clock_set_field_editor_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  editor_state_t shadow;
  out_item_t     pending_readouts[$];
  stim_row_t     directed_rows[$];
  int            failures = 0;
  int            readout_count = 0;
  int            cycle_count = 0;
  int            burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- shadow model
  function automatic int wrap_inc(input int v, input int top, input int low, input int mask);
    return (v >= top) ? low : ((v + 1) & mask);
  endfunction

  function automatic int wrap_dec(input int v, input int bottom, input int top,
                                  input int mask);
    return (v == bottom) ? top : ((v - 1) & mask);
  endfunction

  function automatic int days_in_month(input logic [3:0] month, input logic [6:0] year);
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: return DAY_SHORT;
      4'd2:                    return (year % 4 == 0) ? DAY_FEB_LP : DAY_FEB;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return DAY_LONG;
      default:                 return 0;
    endcase
  endfunction

  function automatic void step_selected(input bit up);
    int lim;
    case (shadow.cursor)
      CUR_YEAR: shadow.year = 7'(up ? wrap_inc(shadow.year, YEAR_MAX, 0, 'h7f)
                                    : wrap_dec(shadow.year, 0, YEAR_MAX, 'h7f));
      CUR_MONTH: shadow.month = 4'(up ? wrap_inc(shadow.month, MONTH_MAX, MONTH_MIN, 'hf)
                                      : wrap_dec(shadow.month, MONTH_MIN, MONTH_MAX, 'hf));
      CUR_DAY: begin
        lim = days_in_month(shadow.month, shadow.year);
        // month out of range: day is frozen
        if (lim != 0)
          shadow.day = 5'(up ? wrap_inc(shadow.day, lim, DAY_MIN, 'h1f)
                             : wrap_dec(shadow.day, DAY_MIN, lim, 'h1f));
      end
      CUR_WEEKDAY: begin
        shadow.offset  = 3'(up ? wrap_inc(shadow.offset, WDAY_MAX, WDAY_MIN, 'h7)
                               : wrap_dec(shadow.offset, WDAY_MIN, WDAY_MAX, 'h7));
        shadow.weekday = 3'(up ? wrap_inc(shadow.weekday, WDAY_MAX, WDAY_MIN, 'h7)
                               : wrap_dec(shadow.weekday, WDAY_MIN, WDAY_MAX, 'h7));
      end
      CUR_HOUR: shadow.hour = 5'(up ? wrap_inc(shadow.hour, HOUR_MAX, 0, 'h1f)
                                    : wrap_dec(shadow.hour, 0, HOUR_MAX, 'h1f));
      CUR_MINUTE: shadow.minute = 6'(up ? wrap_inc(shadow.minute, MINSEC_MAX, 0, 'h3f)
                                        : wrap_dec(shadow.minute, 0, MINSEC_MAX, 'h3f));
      CUR_SECOND: shadow.second = 6'(up ? wrap_inc(shadow.second, MINSEC_MAX, 0, 'h3f)
                                        : wrap_dec(shadow.second, 0, MINSEC_MAX, 'h3f));
      default: ;
    endcase
  endfunction

  function automatic out_item_t advance_editor(input in_item_t key);
    out_item_t r;
    logic      commit;
    commit = 1'b0;
    if (!shadow.edit) begin
      if (key.req_type == REQ_LOAD) begin
        shadow.year    = key.load_year;
        shadow.month   = key.load_month;
        shadow.day     = key.load_day;
        shadow.weekday = key.load_weekday;
        shadow.hour    = key.load_hour;
        shadow.minute  = key.load_minute;
        shadow.second  = key.load_second;
      end else if (key.req_type == REQ_MODE) begin
        shadow.edit   = 1'b1;
        shadow.cursor = CUR_YEAR;
      end
    end else begin
      case (key.req_type)
        REQ_MODE: begin
          shadow.edit = 1'b0;
          commit      = 1'b1;
        end
        REQ_NEXT: shadow.cursor = (shadow.cursor >= CUR_SECOND) ? CUR_YEAR
                                                                : shadow.cursor + 3'd1;
        REQ_INC:  step_selected(1'b1);
        REQ_DEC:  step_selected(1'b0);
        default: ;
      endcase
    end
    r.editing         = shadow.edit;
    r.cursor_pos      = shadow.cursor;
    r.year_out        = shadow.year;
    r.month_out       = shadow.month;
    r.day_out         = shadow.day;
    r.weekday_out     = shadow.weekday;
    r.hour_out        = shadow.hour;
    r.minute_out      = shadow.minute;
    r.second_out      = shadow.second;
    r.week_offset_out = shadow.offset;
    r.commit          = commit;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic log_failure(input string msg);
    if (failures < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_failure($sformatf("readout %0d %s: got %0d expected %0d",
                            readout_count, name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d readouts outstanding",
               cycle_count, pending_readouts.size());
      $display("Test completed with failures");
      $finish;
    end else if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_readouts.size() == 0) begin
        log_failure($sformatf("readout %0d arrived with nothing expected", readout_count));
      end else begin
        want = pending_readouts.pop_front();
        check_field("editing", rsp_ch.editing, want.editing);
        check_field("cursor_pos", rsp_ch.cursor_pos, want.cursor_pos);
        check_field("year_out", rsp_ch.year_out, want.year_out);
        check_field("month_out", rsp_ch.month_out, want.month_out);
        check_field("day_out", rsp_ch.day_out, want.day_out);
        check_field("weekday_out", rsp_ch.weekday_out, want.weekday_out);
        check_field("hour_out", rsp_ch.hour_out, want.hour_out);
        check_field("minute_out", rsp_ch.minute_out, want.minute_out);
        check_field("second_out", rsp_ch.second_out, want.second_out);
        check_field("week_offset_out", rsp_ch.week_offset_out, want.week_offset_out);
        check_field("commit", rsp_ch.commit, want.commit);
      end
      readout_count++;
    end
  end

  // receiver: ready follows a 16-bit pattern, redrawn when the 6-bit phase counter wraps
  initial begin
    logic [15:0] stall_pattern;
    logic [5:0]  stall_phase;
    stall_pattern = 16'hffff;
    stall_phase   = '0;
    rsp_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_phase == 0) begin
        if ($urandom_range(0, 3) == 0) stall_pattern = 16'hffff;
        else stall_pattern = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
      end
      rsp_ch.ready <= stall_pattern[stall_phase[3:0]];
      stall_phase++;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic in_item_t key_with_noise(input logic [2:0] code);
    in_item_t k;
    k.req_type     = code;
    k.load_year    = 7'($urandom);
    k.load_month   = 4'($urandom);
    k.load_day     = 5'($urandom);
    k.load_weekday = 3'($urandom);
    k.load_hour    = 5'($urandom);
    k.load_minute  = 6'($urandom);
    k.load_second  = 6'($urandom);
    return k;
  endfunction

  function automatic in_item_t load_key(input int y, input int m, input int d, input int w,
                                        input int h, input int mi, input int s);
    in_item_t k;
    k.req_type     = REQ_LOAD;
    k.load_year    = 7'(y);
    k.load_month   = 4'(m);
    k.load_day     = 5'(d);
    k.load_weekday = 3'(w);
    k.load_hour    = 5'(h);
    k.load_minute  = 6'(mi);
    k.load_second  = 6'(s);
    return k;
  endfunction

  function automatic in_item_t bare_key(input logic [2:0] code);
    return load_key(0, 0, 0, 0, 0, 0, 0) | (in_item_t'(code) << ($bits(in_item_t) - 3));
  endfunction

  // mostly plausible clock-chip readings, sometimes raw bus values
  function automatic in_item_t random_load();
    if ($urandom_range(0, 3) == 0) return key_with_noise(REQ_LOAD);
    return load_key($urandom_range(0, 99), $urandom_range(1, 12), $urandom_range(1, 31),
                    $urandom_range(0, 7), $urandom_range(0, 23), $urandom_range(0, 59),
                    $urandom_range(0, 59));
  endfunction

  function automatic void add_row(input in_item_t key, input bit typed = 1'b0,
                                  input out_item_t want = '0);
    stim_row_t row;
    row.key   = key;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  task automatic send_key(input in_item_t key, input bit typed, input out_item_t want);
    int        gap;
    out_item_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk) req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    req_ch.req_type     <= key.req_type;
    req_ch.load_year    <= key.load_year;
    req_ch.load_month   <= key.load_month;
    req_ch.load_day     <= key.load_day;
    req_ch.load_weekday <= key.load_weekday;
    req_ch.load_hour    <= key.load_hour;
    req_ch.load_minute  <= key.load_minute;
    req_ch.load_second  <= key.load_second;
    req_ch.valid        <= 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predicted = advance_editor(key);
    pending_readouts.push_back(typed ? want : predicted);
  endtask

  task automatic hold_until_drained();
    @(negedge clk) req_ch.valid <= 1'b0;
    wait (pending_readouts.size() == 0);
  endtask

  initial begin
    in_item_t key;
    int       counted;
    int       pick;
    bit       useful;
    bit       pressured;

    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.load_year = '0;
    req_ch.load_month = '0;
    req_ch.load_day = '0;
    req_ch.load_weekday = '0;
    req_ch.load_hour = '0;
    req_ch.load_minute = '0;
    req_ch.load_second = '0;

    shadow.edit    = 1'b0;
    shadow.cursor  = RST_CURSOR;
    shadow.year    = RST_YEAR;
    shadow.month   = RST_MONTH;
    shadow.day     = RST_DAY;
    shadow.weekday = RST_WEEKDAY;
    shadow.hour    = RST_HOUR;
    shadow.minute  = RST_MINUTE;
    shadow.second  = RST_SECOND;
    shadow.offset  = RST_OFFSET;

    // undefined code right after reset shows the power-on state
    add_row(bare_key(REQ_RSVD5), 1'b1, '{1'b0, RST_CURSOR, RST_YEAR, RST_MONTH, RST_DAY,
            RST_WEEKDAY, RST_HOUR, RST_MINUTE, RST_SECOND, RST_OFFSET, 1'b0});
    add_row(bare_key(REQ_INC));                  // ignored outside editing
    add_row(load_key(127, 15, 31, 7, 31, 63, 63), 1'b1,
            '{1'b0, 3'd1, 7'd127, 4'd15, 5'd31, 3'd7, 5'd31, 6'd63, 6'd63, RST_OFFSET, 1'b0});
    add_row(bare_key(REQ_MODE));
    add_row(load_key(5, 5, 5, 5, 5, 5, 5));      // load while editing is dropped
    add_row(bare_key(REQ_INC));                  // year above max wraps to 0
    add_row(bare_key(REQ_DEC));                  // year 0 down to max
    add_row(bare_key(REQ_NEXT));
    add_row(bare_key(REQ_INC));                  // month 15 up to 1
    add_row(bare_key(REQ_DEC));                  // month 1 down to 12
    add_row(bare_key(REQ_NEXT));
    add_row(bare_key(REQ_INC));                  // day 31 in December wraps
    add_row(bare_key(REQ_NEXT));
    add_row(bare_key(REQ_INC));                  // weekday and offset at 7 wrap to 1
    add_row(bare_key(REQ_NEXT));
    add_row(bare_key(REQ_INC));                  // hour 31 wraps to 0
    add_row(bare_key(REQ_NEXT));
    add_row(bare_key(REQ_INC));                  // minute 63 wraps to 0
    add_row(bare_key(REQ_NEXT));
    add_row(bare_key(REQ_DEC));                  // second 63 steps down
    add_row(bare_key(REQ_NEXT));                 // cursor wraps back to year
    add_row(bare_key(REQ_MODE));                 // leave edit, commit
    add_row(load_key(0, 0, 0, 0, 0, 0, 0), 1'b1,
            '{1'b0, 3'd1, 7'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0, 6'd0, 3'd1, 1'b0});
    add_row(bare_key(REQ_MODE));
    add_row(bare_key(REQ_NEXT));
    add_row(bare_key(REQ_DEC));                  // month 0 wraps in register width
    add_row(bare_key(REQ_NEXT));
    add_row(bare_key(REQ_INC));                  // month 15 invalid: day unchanged

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_rows[i])
      send_key(directed_rows[i].key, directed_rows[i].typed, directed_rows[i].want);
    hold_until_drained();

    counted   = 0;
    pressured = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (!shadow.edit) begin
        if (pick < 8)       key = key_with_noise(3'($urandom_range(REQ_NEXT, REQ_RSVD7)));
        else if (pick < 45) key = random_load();
        else                key = key_with_noise(REQ_MODE);
        useful = (key.req_type == REQ_LOAD || key.req_type == REQ_MODE);
      end else begin
        if (pick < 2)       key = key_with_noise(REQ_LOAD);
        else if (pick < 4)  key = key_with_noise(3'($urandom_range(REQ_RSVD5, REQ_RSVD7)));
        else if (pick < 10) key = key_with_noise(REQ_MODE);
        else if (pick < 35) key = key_with_noise(REQ_NEXT);
        else if (pick < 70) key = key_with_noise(REQ_INC);
        else                key = key_with_noise(REQ_DEC);
        useful = (key.req_type inside {REQ_MODE, REQ_NEXT, REQ_INC, REQ_DEC});
      end
      send_key(key, 1'b0, '0);
      if (useful) counted++;
      if (!pressured && counted >= RANDOM_ITEMS / 2) begin
        hold_until_drained();
        pressured = 1'b1;
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
rtl/cse_pkg.sv
rtl/cse_if.sv
rtl/cse_in_reg.sv
rtl/cse_core.sv
rtl/clock_set_field_editor_unit.sv
rtl/cse_checker.sv
tb/sv/tb_clock_set_field_editor_unit.sv
